// ===== design/bate_pkg.sv =====
// ----------------------------------------------------------------------------
// bate_pkg: shared types and constants of the bounded list engine
// Operation and status codes, sequencer states, default depth.
// ----------------------------------------------------------------------------
`default_nettype none
package bate_pkg;
  localparam int unsigned DefaultDepth = 8;

  typedef enum logic [2:0] {
    OP_APPEND  = 3'd0,
    OP_DELETE  = 3'd1,
    OP_SORT    = 3'd2,
    OP_SEARCH  = 3'd3,
    OP_DISPLAY = 3'd4,
    OP_REVERSE = 3'd5,
    OP_RSVD6   = 3'd6,
    OP_RSVD7   = 3'd7
  } op_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_NOPOS    = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_A,
    S_RD_B,
    S_WR_A,
    S_WR_B,
    S_OUT
  } state_e;
endpackage
`default_nettype wire

// ===== design/bounded_array_table_engine_core.sv =====
// ----------------------------------------------------------------------------
// bounded_array_table_engine_core: bounded list of signed 32-bit values
// Append, delete, sort, search, display and reverse over one memory.
// ----------------------------------------------------------------------------
// The list lives in a single-port synchronous RAM of DEPTH entries (one read
// or one write a cycle, read data registered). Sort and reverse work in
// two-entry steps: read a, read b, write a, write b. Delete moves each entry
// behind the position down with read b, write a. Append and the rejected
// cases go from the accept straight to the result transfer. Search reads
// one entry per step, display gives a result transfer per entry shown.
// Sort is a bubble sort on the memory port: at most n*(n-1)/2 compare
// steps, which makes it the longest item. One item is in work at a time;
// the input is ready again in the cycle after the final result transfer of
// an item.
`default_nettype none
module bounded_array_table_engine_core #(
  parameter int unsigned DEPTH = bate_pkg::DefaultDepth
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [2:0]         op_i,
  input  wire logic signed [31:0] value_i,
  input  wire logic [7:0]         position_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [2:0]              status_o,
  output logic [6:0]              found_position_o,
  output logic signed [31:0]      element_o,
  output logic                    last_o
);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  bate_pkg::state_e state_q, state_d;
  logic [2:0]        op_q;
  logic [31:0]       val_q;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [CW-1:0]     i_q, i_d, j_q, j_d;   // step indexes
  logic [CW-1:0]     lim_q, lim_d;         // sort pass limit
  logic              swp_q, swp_d;         // sort: swap seen in pass
  logic [31:0]       a_q, a_d, b_q, b_d;
  logic [31:0]       rdata_q;
  logic              rvalid_q;
  logic [31:0]       mem_q [DEPTH];

  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_addr;
  logic [31:0]       mem_wdata;

  logic [2:0]        res_st_q, res_st_d;
  logic [6:0]        res_fp_q, res_fp_d;
  logic [31:0]       res_el_q, res_el_d;
  logic              res_last_q, res_last_d;

  logic acc;
  assign acc = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == bate_pkg::S_IDLE);

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_addr] <= mem_wdata;
    if (mem_re) rdata_q <= mem_q[mem_addr];
  end

  // next state and datapath
  always_comb begin
    state_d = state_q; cnt_d = cnt_q; i_d = i_q; j_d = j_q; lim_d = lim_q;
    swp_d = swp_q; a_d = a_q; b_d = b_q;
    res_st_d = res_st_q; res_fp_d = res_fp_q; res_el_d = res_el_q;
    res_last_d = res_last_q;
    unique case (state_q)
      bate_pkg::S_IDLE: begin
        if (acc) begin
          res_st_d = bate_pkg::ST_OK; res_fp_d = '0; res_el_d = '0;
          res_last_d = 1'b1; state_d = bate_pkg::S_OUT;
          if (op_i > 3'(bate_pkg::OP_REVERSE)) begin
            state_d = bate_pkg::S_IDLE;
          end else if (op_i == 3'(bate_pkg::OP_APPEND)) begin
            if (cnt_q >= CW'(DEPTH)) res_st_d = bate_pkg::ST_FULL;
            else cnt_d = cnt_q + 1'b1;
          end else if (cnt_q == '0) begin
            res_st_d = bate_pkg::ST_EMPTY;
          end else begin
            unique case (op_i)
              3'(bate_pkg::OP_DELETE): begin
                if (position_i == '0 || position_i > 8'(cnt_q)) begin
                  res_st_d = bate_pkg::ST_NOPOS;
                end else begin
                  i_d = CW'(position_i - 8'd1); j_d = CW'(position_i);
                  cnt_d = cnt_q - 1'b1;
                  state_d = (i_d + 1'b1 < cnt_q) ? bate_pkg::S_RD_B : bate_pkg::S_OUT;
                end
              end
              3'(bate_pkg::OP_SORT): begin
                i_d = '0; j_d = CW'(1); lim_d = cnt_q; swp_d = 1'b0;
                state_d = (cnt_q > CW'(1)) ? bate_pkg::S_RD_A : bate_pkg::S_OUT;
              end
              3'(bate_pkg::OP_REVERSE): begin
                i_d = '0; j_d = cnt_q - 1'b1;
                state_d = (cnt_q > CW'(1)) ? bate_pkg::S_RD_A : bate_pkg::S_OUT;
              end
              default: begin // search, display: scan through a
                i_d = '0; state_d = bate_pkg::S_RD_A;
              end
            endcase
          end
        end
      end
      bate_pkg::S_RD_A: state_d = bate_pkg::S_RD_B;
      bate_pkg::S_RD_B: begin
        if (rvalid_q) a_d = rdata_q;
        if (op_q == 3'(bate_pkg::OP_SEARCH) || op_q == 3'(bate_pkg::OP_DISPLAY)) begin
          // rdata holds entry i
          state_d = bate_pkg::S_OUT;
          if (op_q == 3'(bate_pkg::OP_DISPLAY)) begin
            res_el_d = rdata_q; res_last_d = (i_q + 1'b1 == cnt_q);
          end else if (rdata_q == val_q) begin
            res_fp_d = 7'(i_q + 1'b1);
          end else if (i_q + 1'b1 == cnt_q) begin
            res_st_d = bate_pkg::ST_NOTFOUND;
          end else begin
            i_d = i_q + 1'b1; state_d = bate_pkg::S_RD_A;
          end
        end else begin
          state_d = bate_pkg::S_WR_A;
        end
      end
      bate_pkg::S_WR_A: begin
        b_d = rdata_q; // entry j
        if (op_q == 3'(bate_pkg::OP_DELETE)) begin
          // entry i <= entry j
          i_d = i_q + 1'b1; j_d = j_q + 1'b1;
          state_d = (j_q + 1'b1 < cnt_q + 1'b1) ? bate_pkg::S_RD_B : bate_pkg::S_OUT;
        end else begin
          state_d = bate_pkg::S_WR_B;
        end
      end
      bate_pkg::S_WR_B: begin
        if (op_q == 3'(bate_pkg::OP_REVERSE)) begin
          i_d = i_q + 1'b1; j_d = j_q - 1'b1;
          state_d = (i_q + 1'b1 < j_q - 1'b1) ? bate_pkg::S_RD_A : bate_pkg::S_OUT;
        end else begin
          if ($signed(b_q) < $signed(a_q)) swp_d = 1'b1;
          if (j_q + 1'b1 < lim_q) begin
            i_d = i_q + 1'b1; j_d = j_q + 1'b1; state_d = bate_pkg::S_RD_A;
          end else if ((swp_q || $signed(b_q) < $signed(a_q)) && lim_q > CW'(2)) begin
            lim_d = lim_q - 1'b1; i_d = '0; j_d = CW'(1); swp_d = 1'b0;
            state_d = bate_pkg::S_RD_A;
          end else begin
            state_d = bate_pkg::S_OUT;
          end
        end
      end
      bate_pkg::S_OUT: begin
        if (out_ready_i) begin
          if (op_q == 3'(bate_pkg::OP_DISPLAY) && !res_last_q &&
              res_st_q == bate_pkg::ST_OK) begin
            i_d = i_q + 1'b1; state_d = bate_pkg::S_RD_A;
          end else begin
            state_d = bate_pkg::S_IDLE;
          end
        end
      end
      default: state_d = bate_pkg::S_IDLE;
    endcase
  end

  // memory port control
  always_comb begin
    mem_we = 1'b0; mem_re = 1'b0; mem_addr = '0; mem_wdata = '0;
    unique case (state_q)
      bate_pkg::S_IDLE: begin
        if (acc && op_i == 3'(bate_pkg::OP_APPEND) && cnt_q < CW'(DEPTH)) begin
          mem_we = 1'b1; mem_addr = AW'(cnt_q); mem_wdata = value_i;
        end
      end
      bate_pkg::S_RD_A: begin
        mem_re = 1'b1; mem_addr = AW'(i_q);
      end
      bate_pkg::S_RD_B: begin
        if (op_q != 3'(bate_pkg::OP_SEARCH) && op_q != 3'(bate_pkg::OP_DISPLAY)) begin
          mem_re = 1'b1; mem_addr = AW'(j_q);
        end
      end
      bate_pkg::S_WR_A: begin
        if (op_q == 3'(bate_pkg::OP_DELETE)) begin
          mem_we = 1'b1; mem_addr = AW'(i_q); mem_wdata = rdata_q;
        end else if (op_q == 3'(bate_pkg::OP_REVERSE) ||
                     $signed(rdata_q) < $signed(a_q)) begin
          mem_we = 1'b1; mem_addr = AW'(i_q); mem_wdata = rdata_q;
        end
      end
      bate_pkg::S_WR_B: begin
        if (op_q == 3'(bate_pkg::OP_REVERSE) || $signed(b_q) < $signed(a_q)) begin
          mem_we = 1'b1; mem_addr = AW'(j_q); mem_wdata = a_q;
        end
      end
      bate_pkg::S_OUT: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bate_pkg::S_IDLE;
      cnt_q <= '0; i_q <= '0; j_q <= '0; lim_q <= '0; swp_q <= 1'b0;
      rvalid_q <= 1'b0; op_q <= '0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d; i_q <= i_d; j_q <= j_d; lim_q <= lim_d; swp_q <= swp_d;
      rvalid_q <= mem_re;
      if (acc) op_q <= op_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) val_q <= value_i;
    a_q <= a_d; b_q <= b_d;
    res_st_q <= res_st_d; res_fp_q <= res_fp_d;
    res_el_q <= res_el_d; res_last_q <= res_last_d;
  end

  assign out_valid_o      = (state_q == bate_pkg::S_OUT);
  assign status_o         = res_st_q;
  assign found_position_o = res_fp_q;
  assign element_o        = res_el_q;
  assign last_o           = res_last_q;

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(DEPTH)) else $error("count above depth");
  a_out_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(res_el_q))
    else $error("result dropped while stalled");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != bate_pkg::S_IDLE |-> !in_ready_o) else $error("accept while busy");
  a_we_re: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && mem_re)) else $error("port conflict");
endmodule
`default_nettype wire
